FILE: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int OCC_W       = 5;

	// Item kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// One stored entry
	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	// Operation broadcast to every cell
	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/spq_cell.sv
// One slot of the sorted shift chain.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire spq_pkg::cmd_t   cmd,
	input  wire spq_pkg::entry_t left_ent,
	input  wire logic          left_behind,
	input  wire spq_pkg::entry_t right_ent,
	output spq_pkg::entry_t    ent,
	output logic               behind
);

	logic                     valid_q;
	logic signed [spq_pkg::DATA_W-1:0] value_q;
	logic signed [spq_pkg::DATA_W-1:0] prio_q;
	spq_pkg::entry_t          nxt;

	assign ent = '{valid: valid_q, value: value_q, prio: prio_q};

	// new entry goes at or ahead of this slot
	assign behind = !valid_q || (prio_q > cmd.prio);

	always_comb begin
		nxt = ent;
		if (cmd.ins) begin
			if (behind) begin
				if (left_behind) begin
					nxt = left_ent;
				end else begin
					nxt = '{valid: 1'b1, value: cmd.value, prio: cmd.prio};
				end
			end
		end else if (cmd.rem) begin
			nxt = right_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= nxt.value;
		prio_q  <= nxt.prio;
	end

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: chain of spq_cell slots plus result register.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Sorted priority queue of spq_pkg::QUEUE_DEPTH entries, kept in ascending
// signed priority order in a row of cells; the head is always cell 0. One item
// is taken every cycle: busy never rises, since every cell compares the new
// priority against its own entry and shifts in the same cycle. An item
// accepted at a clock edge (start high, busy low) gives its result in the next
// cycle on value_out/status/occupancy with done high for exactly that one
// cycle. The receiver cannot stall: the result must be captured while done is
// high. Insert into a full queue is dropped (STAT_FULL); remove from an empty
// queue reports STAT_EMPTY. Equal priorities leave in arrival order.
module sorted_priority_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               kind,
	input  wire logic signed [31:0] value_in,
	input  wire logic signed [31:0] prio_in,
	output logic                    done,
	output logic signed [31:0]      value_out,
	output logic [1:0]              status,
	output logic [4:0]              occupancy
);

	localparam int N = spq_pkg::QUEUE_DEPTH;

	spq_pkg::entry_t ent      [N];
	logic            behind   [N];
	logic [N-1:0]    valid_vec;
	spq_pkg::cmd_t   cmd;

	logic                        accept;
	logic                        full;
	logic                        empty;
	logic [spq_pkg::CNT_W-1:0]   count_q;
	logic                        done_q;
	logic signed [31:0]          value_q;
	spq_pkg::status_t            status_q;

	// update applied without waiting, never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign empty = !ent[0].valid;
	assign full  = ent[N-1].valid;

	assign cmd.ins   = accept && (kind == spq_pkg::KIND_INSERT) && !full;
	assign cmd.rem   = accept && (kind == spq_pkg::KIND_REMOVE) && !empty;
	assign cmd.value = value_in;
	assign cmd.prio  = prio_in;

	// Chain: left neighbor feeds inserts, right neighbor feeds removes.
	for (genvar i = 0; i < N; i++) begin : g_cell
		spq_pkg::entry_t left_ent;
		spq_pkg::entry_t right_ent;
		logic            left_behind;

		if (i == 0) begin : g_head
			assign left_ent    = '0;
			assign left_behind = 1'b0;
		end else begin : g_mid
			assign left_ent    = ent[i-1];
			assign left_behind = behind[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign right_ent = '0;
		end else begin : g_body
			assign right_ent = ent[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_ent    (left_ent),
			.left_behind (left_behind),
			.right_ent   (right_ent),
			.ent         (ent[i]),
			.behind      (behind[i])
		);

		assign valid_vec[i] = ent[i].valid;
	end

	// Fill count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			done_q   <= 1'b0;
			value_q  <= '0;
			status_q <= spq_pkg::STAT_OK;
		end else begin
			done_q <= accept;
			if (accept) begin
				value_q  <= '0;
				status_q <= spq_pkg::STAT_OK;
				if (kind == spq_pkg::KIND_INSERT) begin
					if (full) begin
						status_q <= spq_pkg::STAT_FULL;
					end else begin
						count_q <= count_q + 1'b1;
					end
				end else begin
					if (empty) begin
						status_q <= spq_pkg::STAT_EMPTY;
					end else begin
						value_q <= ent[0].value;
						count_q <= count_q - 1'b1;
					end
				end
			end
		end
	end

	assign done      = done_q;
	assign value_out = value_q;
	assign status    = status_q;
	assign occupancy = 5'(count_q);

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------

	// count tracks the filled prefix of the chain
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(count_q))
		else $error("fill count differs from valid cells");

	// valid cells form a contiguous prefix
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + 1'b1) & valid_vec) == '0)
		else $error("hole in cell chain");

	// empty report only with an empty queue
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spq_pkg::STAT_EMPTY) |-> (count_q == '0))
		else $error("empty status with entries stored");

	// full report only with a full queue
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spq_pkg::STAT_FULL) |-> (32'(count_q) == N))
		else $error("full status with room left");

endmodule

`default_nettype wire
